FILE: src/pbrle_pkg.sv
// ----------------------------------------------------------------------------
// pbrle_pkg
// shared types and constants of the packbits run-length decoder
// ----------------------------------------------------------------------------
package pbrle_pkg;

	localparam int LENGTH_BITS = 24;
	localparam logic [7:0] MAX_SECTION = 8'd128;
	localparam logic [LENGTH_BITS-1:0] OUT_LENGTH_RESET = LENGTH_BITS'(4096);

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam int WORD_BYTES = 4;
	localparam logic [7:0] WORD_BYTES_8 = 8'(WORD_BYTES);

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LITERAL = 2'd1,
		PH_RUN     = 2'd2,
		PH_WAIT    = 2'd3
	} phase_t;

	// one command for the back end: repeat value count times, or report overflow
	typedef struct packed {
		logic       ovf;
		logic [7:0] value;
		logic [7:0] count;
		logic       done;
	} pbrle_cmd_t;

endpackage

FILE: src/pbrle_front.sv
// ----------------------------------------------------------------------------
// pbrle_front
// header parsing, length bookkeeping and command generation
// ----------------------------------------------------------------------------
module pbrle_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pbrle_pkg::LENGTH_BITS-1:0] cfg_wr_data,
	input  logic                              accept_i,
	input  logic [7:0]                        byte_i,
	output logic                              push_o,
	output pbrle_pkg::pbrle_cmd_t             cmd_o
);

	pbrle_pkg::phase_t phase_q, phase_d;
	logic [pbrle_pkg::LENGTH_BITS-1:0] out_length_q;
	logic [pbrle_pkg::LENGTH_BITS-1:0] total_q;
	logic [7:0] literal_left_q;
	logic [7:0] run_length_q;

	logic [7:0] hdr_n;
	logic [pbrle_pkg::LENGTH_BITS:0] hdr_sum;
	logic hdr_ovf;
	logic is_skip;
	logic [pbrle_pkg::LENGTH_BITS-1:0] lit_total;
	logic [pbrle_pkg::LENGTH_BITS-1:0] run_total;
	logic lit_done;
	logic run_done;

	always_comb begin
		hdr_n = byte_i[7] ? (8'd1 - byte_i) : (byte_i + 8'd1);
		hdr_sum = {1'b0, total_q} + {{(pbrle_pkg::LENGTH_BITS-7){1'b0}}, hdr_n};
		hdr_ovf = hdr_sum > {1'b0, out_length_q};
		is_skip = byte_i == pbrle_pkg::MAX_SECTION;
		lit_total = total_q + pbrle_pkg::LENGTH_BITS'(1);
		run_total = total_q + pbrle_pkg::LENGTH_BITS'(run_length_q);
		lit_done = lit_total == out_length_q;
		run_done = run_total == out_length_q;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			pbrle_pkg::PH_HEADER: begin
				if (!is_skip) begin
					if (hdr_ovf)
						phase_d = pbrle_pkg::PH_WAIT;
					else if (byte_i[7])
						phase_d = pbrle_pkg::PH_RUN;
					else
						phase_d = pbrle_pkg::PH_LITERAL;
				end
			end
			pbrle_pkg::PH_LITERAL: begin
				if (lit_done)
					phase_d = pbrle_pkg::PH_WAIT;
				else if (literal_left_q == 8'd1)
					phase_d = pbrle_pkg::PH_HEADER;
			end
			pbrle_pkg::PH_RUN: begin
				phase_d = run_done ? pbrle_pkg::PH_WAIT : pbrle_pkg::PH_HEADER;
			end
			default: phase_d = phase_q;
		endcase
	end

	// outputs
	always_comb begin
		push_o = 1'b0;
		cmd_o.ovf = 1'b0;
		cmd_o.value = byte_i;
		cmd_o.count = 8'd1;
		cmd_o.done = 1'b0;
		case (phase_q)
			pbrle_pkg::PH_HEADER: begin
				push_o = accept_i && !is_skip && hdr_ovf;
				cmd_o.ovf = 1'b1;
			end
			pbrle_pkg::PH_LITERAL: begin
				push_o = accept_i;
				cmd_o.done = lit_done;
			end
			pbrle_pkg::PH_RUN: begin
				push_o = accept_i;
				cmd_o.count = run_length_q;
				cmd_o.done = run_done;
			end
			default: push_o = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pbrle_pkg::PH_HEADER;
			out_length_q <= pbrle_pkg::OUT_LENGTH_RESET;
			total_q <= '0;
			literal_left_q <= '0;
			run_length_q <= '0;
		end else if (cfg_wr_en) begin
			phase_q <= pbrle_pkg::PH_HEADER;
			out_length_q <= cfg_wr_data;
			total_q <= '0;
			literal_left_q <= '0;
			run_length_q <= '0;
		end else if (accept_i) begin
			phase_q <= phase_d;
			case (phase_q)
				pbrle_pkg::PH_HEADER: begin
					if (!is_skip && !hdr_ovf) begin
						if (byte_i[7])
							run_length_q <= hdr_n;
						else
							literal_left_q <= hdr_n;
					end
				end
				pbrle_pkg::PH_LITERAL: begin
					total_q <= lit_total;
					literal_left_q <= literal_left_q - 8'd1;
				end
				pbrle_pkg::PH_RUN: begin
					total_q <= run_total;
					run_length_q <= '0;
				end
				default: total_q <= total_q;
			endcase
		end
	end

endmodule

FILE: src/pbrle_cmdq.sv
// ----------------------------------------------------------------------------
// pbrle_cmdq
// short command queue between front and back end
// ----------------------------------------------------------------------------
module pbrle_cmdq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_i,
	input  pbrle_pkg::pbrle_cmd_t cmd_i,
	output logic                  full_o,
	input  logic                  pop_i,
	output logic                  empty_o,
	output pbrle_pkg::pbrle_cmd_t head_o
);

	pbrle_pkg::pbrle_cmd_t mem_q [pbrle_pkg::CMDQ_DEPTH];
	logic [pbrle_pkg::CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [pbrle_pkg::CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [pbrle_pkg::CMDQ_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full_o = count_q == pbrle_pkg::CMDQ_CNT_W'(pbrle_pkg::CMDQ_DEPTH);
	assign empty_o = count_q == '0;
	assign head_o = mem_q[rd_ptr_q];
	assign do_push = push_i && !full_o;
	assign do_pop = pop_i && !empty_o;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= cmd_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == pbrle_pkg::CMDQ_PTR_W'(pbrle_pkg::CMDQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + pbrle_pkg::CMDQ_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == pbrle_pkg::CMDQ_PTR_W'(pbrle_pkg::CMDQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + pbrle_pkg::CMDQ_PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + pbrle_pkg::CMDQ_CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - pbrle_pkg::CMDQ_CNT_W'(1);
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_i |-> !full_o)
		else $error("command pushed into full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= pbrle_pkg::CMDQ_CNT_W'(pbrle_pkg::CMDQ_DEPTH))
		else $error("command queue count out of range");

endmodule

FILE: src/pbrle_back.sv
// ----------------------------------------------------------------------------
// pbrle_back
// expands commands into result words and holds the output register
// ----------------------------------------------------------------------------
module pbrle_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty_i,
	input  pbrle_pkg::pbrle_cmd_t head_i,
	output logic                  q_pop_o,
	input  logic                  pop,
	output logic                  empty,
	output logic [31:0]           data_word,
	output logic [2:0]            byte_count,
	output logic                  last,
	output logic                  block_done,
	output logic                  status
);

	logic       busy_q;
	logic [7:0] value_q;
	logic [7:0] left_q;
	logic       done_q;
	logic       out_valid_q;

	logic       have;
	logic       load;
	logic [7:0] cur_value;
	logic [7:0] cur_left;
	logic       cur_done;
	logic       cur_ovf;
	logic [2:0] cnt;
	logic       last_word;
	logic [31:0] word;

	always_comb begin
		cur_value = busy_q ? value_q : head_i.value;
		cur_left = busy_q ? left_q : head_i.count;
		cur_done = busy_q ? done_q : head_i.done;
		cur_ovf = !busy_q && head_i.ovf;
		have = busy_q || !q_empty_i;
		load = have && (!out_valid_q || pop);
		last_word = cur_left <= pbrle_pkg::WORD_BYTES_8;
		cnt = last_word ? cur_left[2:0] : 3'(pbrle_pkg::WORD_BYTES);
		for (int i = 0; i < pbrle_pkg::WORD_BYTES; i++)
			word[8*i +: 8] = (3'(i) < cnt) ? cur_value : 8'd0;
	end

	assign q_pop_o = load && !busy_q;
	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				busy_q <= !cur_ovf && !last_word;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= cur_value;
			left_q <= cur_left - pbrle_pkg::WORD_BYTES_8;
			done_q <= cur_done;
			if (cur_ovf) begin
				data_word <= '0;
				byte_count <= '0;
				last <= 1'b1;
				block_done <= 1'b0;
				status <= 1'b1;
			end else begin
				data_word <= word;
				byte_count <= cnt;
				last <= last_word;
				block_done <= cur_done && last_word;
				status <= 1'b0;
			end
		end
	end

	a_busy_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> left_q != 8'd0)
		else $error("run expansion active with no bytes left");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && block_done) |-> (last && !status && byte_count != 3'd0))
		else $error("block done flagged on a non-final result");

	a_ovf_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status) |-> (last && byte_count == 3'd0 && data_word == 32'd0))
		else $error("malformed overflow result");

endmodule

FILE: src/packbits_rle_decoder.sv
// ----------------------------------------------------------------------------
// packbits_rle_decoder
// packbits run-length decoder with word-wide run expansion
// ----------------------------------------------------------------------------
// input queue side: comp_byte is taken when push is high and full is low
// result queue side: the oldest result sits on the result ports while empty is
//   low and leaves when pop is high
// config: cfg_wr_en writes cfg_wr_data to the output length and restarts the
//   block; write only while idle
// a literal byte gives one result with one byte; a run of n bytes gives
//   ceil(n/4) word results; an overflow gives one status-only result
// a result passes the command queue and then the output register before it
//   shows up on the result ports
// throughput: one input byte per cycle for headers and literals while the
//   command queue is not full; the back end emits one word per cycle while
//   the receiver keeps popping, so a run holds the back end for ceil(n/4)
//   words and input stalls once the 4-entry command queue fills; a stalled
//   receiver holds the output register, the back end waits, and the front
//   keeps taking bytes until the queue is full
// reset: length 4096, expect header, queue and output register empty
// after a done or overflow result input bytes are taken and dropped until the length is written again
// ----------------------------------------------------------------------------
module packbits_rle_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [pbrle_pkg::LENGTH_BITS-1:0] cfg_wr_data,
	input  logic                              push,
	output logic                              full,
	input  logic [7:0]                        comp_byte,
	input  logic                              pop,
	output logic                              empty,
	output logic [31:0]                       data_word,
	output logic [2:0]                        byte_count,
	output logic                              last,
	output logic                              block_done,
	output logic                              status
);

	logic                  accept;
	logic                  cmd_push;
	pbrle_pkg::pbrle_cmd_t cmd;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_pop;
	pbrle_pkg::pbrle_cmd_t q_head;

	assign full = q_full;
	assign accept = push && !q_full;

	pbrle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept_i    (accept),
		.byte_i      (comp_byte),
		.push_o      (cmd_push),
		.cmd_o       (cmd)
	);

	pbrle_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_i  (cmd_push),
		.cmd_i   (cmd),
		.full_o  (q_full),
		.pop_i   (q_pop),
		.empty_o (q_empty),
		.head_o  (q_head)
	);

	pbrle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty_i  (q_empty),
		.head_i     (q_head),
		.q_pop_o    (q_pop),
		.pop        (pop),
		.empty      (empty),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.block_done (block_done),
		.status     (status)
	);

endmodule
